/* hdl/assert_macros.svh */
// Assertion macros for the checker module of this project.
// Depends on nothing; included by the files that hold assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/fsis_pkg.sv */
// Package of the filtered stable insertion sorter: word types, codes and constants.
// Depends on nothing; used by every module of the block.
package fsis_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int KEY_W = 14;
    localparam int GROUP_SIZE = 16;

    localparam logic [7:0] TYPE_A = 8'd200;
    localparam logic [7:0] TYPE_B = 8'd201;
    localparam logic [7:0] KEY_TYPE_MASK = 8'd63;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_OFFER = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [1:0] MODE_ALL = 2'd0;
    localparam logic [1:0] MODE_EXCLUDE = 2'd1;
    localparam logic [1:0] MODE_ONLY = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] item_id;
        logic       item_enabled;
        logic [7:0] filter_type;
        logic [7:0] sort_type;
        logic [7:0] sort_value;
        logic [7:0] read_position;
    } in_word_t;

    typedef struct packed {
        logic [7:0] sorted_item_id;
        logic [8:0] list_count;
        logic       position_valid;
    } out_word_t;

    typedef struct packed {
        logic [7:0]       id;
        logic [KEY_W-1:0] key;
    } entry_t;

    typedef struct packed {
        logic occupied;
        logic at_end;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SEL  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

endpackage

/* hdl/fsis_cell.sv */
// One slot of the insertion row: holds an id and its key and shifts right on insertion.
// Depends on fsis_pkg.
module fsis_cell (
    input  logic               aclk,
    input  logic               ins_en,
    input  fsis_pkg::cell_ctl_t ctl,
    input  fsis_pkg::entry_t   new_entry,
    input  fsis_pkg::entry_t   left_entry,
    input  logic               left_gt,
    output fsis_pkg::entry_t   entry,
    output logic               gt
);

    fsis_pkg::entry_t entry_reg;
    fsis_pkg::entry_t entry_next;

    assign gt = ctl.occupied && (new_entry.key < entry_reg.key);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ins_en) begin
            if (left_gt) begin
                entry_next = left_entry;
            end else if (gt || ctl.at_end) begin
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

/* hdl/fsis_sel.sv */
// Two-step read select over the row of cells: a registered pick within each group of
// sixteen, then a pick of the group. Depends on fsis_pkg.
module fsis_sel #(
    parameter int CAPACITY = fsis_pkg::CAPACITY_DEF
) (
    input  logic       aclk,
    input  logic       load,
    input  logic [7:0] position,
    input  logic [7:0] ids [CAPACITY],
    output logic [7:0] sel_id
);

    localparam int NGRP = (CAPACITY + fsis_pkg::GROUP_SIZE - 1) / fsis_pkg::GROUP_SIZE;
    localparam int GRPW = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int NGRP_PAD = 2 ** GRPW;
    localparam int PAD_DEPTH = NGRP_PAD * fsis_pkg::GROUP_SIZE;
    localparam int LOW_W = $clog2(fsis_pkg::GROUP_SIZE);

    logic [7:0]            padded [PAD_DEPTH];
    logic [7:0]            group_reg [NGRP_PAD];
    logic [GRPW-1:0]       hi_reg;
    logic [GRPW+LOW_W+7:0] pos_ext;

    assign pos_ext = {{(GRPW + LOW_W){1'b0}}, position};

    for (genvar k = 0; k < PAD_DEPTH; k++) begin : g_pad
        if (k < CAPACITY) begin : g_used
            assign padded[k] = ids[k];
        end else begin : g_zero
            assign padded[k] = 8'd0;
        end
    end

    for (genvar g = 0; g < NGRP_PAD; g++) begin : g_grp
        always_ff @(posedge aclk) begin
            if (load) begin
                group_reg[g] <= padded[{GRPW'(g), pos_ext[LOW_W-1:0]}];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            hi_reg <= pos_ext[LOW_W +: GRPW];
        end
    end

    assign sel_id = group_reg[hi_reg];

endmodule

/* hdl/filtered_stable_insertion_sorter.sv */
// Filtered stable insertion sorter, top level.
// Depends on fsis_pkg, fsis_cell and fsis_sel.
//
// Words arrive on the s_ channel (valid/ready) as fsis_pkg::in_word_t. A start word
// empties the list, an offer word is filtered by the filter_mode register and, if
// kept, inserted after all entries with an equal key. A read word returns one
// fsis_pkg::out_word_t on the m_ channel; start and offer words return nothing.
// The list lives in a row of CAPACITY cells. On an offer every cell compares its key
// with the new one at once and either keeps its entry, takes its left neighbor's or
// takes the new one, so an offer completes in the cycle it is accepted and offers
// may follow each other every cycle while no read is pending. A read registers a pick
// within each group of sixteen cells when it is accepted; in state ST_SEL the group is
// picked and the result registered, and it is valid in ST_OUT. s_ready stays low until
// the result is taken. When the receiver stalls, the result holds and no new word is
// accepted. Synchronous reset empties the list, sets filter_mode to zero and drops
// m_valid. filter_mode is written through cfg_wr_en and cfg_wr_data.
module filtered_stable_insertion_sorter #(
    parameter int CAPACITY = fsis_pkg::CAPACITY_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  fsis_pkg::in_word_t  s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output fsis_pkg::out_word_t m_word
);

    localparam int CNTW = $clog2(CAPACITY + 1);

    fsis_pkg::state_t    state_reg;
    fsis_pkg::state_t    state_next;
    logic [CNTW-1:0]     count_reg;
    logic [CNTW-1:0]     count_next;
    logic [1:0]          mode_reg;
    logic                pos_valid_reg;
    fsis_pkg::out_word_t m_word_reg;

    logic                accept;
    logic                special;
    logic                passes;
    logic                ins_en;
    logic                pos_valid;
    logic [7:0]          sel_id;
    logic [CNTW+8:0]     count_ext;
    fsis_pkg::entry_t    new_entry;
    fsis_pkg::entry_t    cells [CAPACITY];
    logic                gts [CAPACITY];
    logic [7:0]          ids [CAPACITY];

    assign s_ready = (state_reg == fsis_pkg::ST_IDLE);
    assign accept = s_valid && s_ready;
    assign m_valid = (state_reg == fsis_pkg::ST_OUT);
    assign m_word = m_word_reg;

    assign special = (s_word.filter_type == fsis_pkg::TYPE_A)
                  || (s_word.filter_type == fsis_pkg::TYPE_B);

    always_comb begin
        case (mode_reg)
            fsis_pkg::MODE_ALL: passes = 1'b1;
            fsis_pkg::MODE_EXCLUDE: passes = !special;
            fsis_pkg::MODE_ONLY: passes = special;
            default: passes = 1'b0;
        endcase
    end

    assign ins_en = accept && (s_word.command == fsis_pkg::CMD_OFFER)
                 && s_word.item_enabled && passes
                 && (count_reg != CNTW'(CAPACITY));

    assign new_entry.id = s_word.item_id;
    assign new_entry.key = {s_word.sort_type[5:0] & fsis_pkg::KEY_TYPE_MASK[5:0],
                            s_word.sort_value};

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        fsis_pkg::cell_ctl_t ctl;
        fsis_pkg::entry_t    left_entry;
        logic                left_gt;

        assign ctl.occupied = CNTW'(i) < count_reg;
        assign ctl.at_end = CNTW'(i) == count_reg;

        if (i == 0) begin : g_first
            assign left_entry = '0;
            assign left_gt = 1'b0;
        end else begin : g_rest
            assign left_entry = cells[i-1];
            assign left_gt = gts[i-1];
        end

        fsis_cell u_cell (
            .aclk       (aclk),
            .ins_en     (ins_en),
            .ctl        (ctl),
            .new_entry  (new_entry),
            .left_entry (left_entry),
            .left_gt    (left_gt),
            .entry      (cells[i]),
            .gt         (gts[i])
        );

        assign ids[i] = cells[i].id;
    end

    fsis_sel #(
        .CAPACITY (CAPACITY)
    ) u_sel (
        .aclk     (aclk),
        .load     (accept),
        .position (s_word.read_position),
        .ids      (ids),
        .sel_id   (sel_id)
    );

    assign pos_valid = {{CNTW{1'b0}}, s_word.read_position} < {8'd0, count_reg};
    assign count_ext = {9'd0, count_reg};

    always_comb begin
        count_next = count_reg;
        if (accept) begin
            case (s_word.command)
                fsis_pkg::CMD_START: count_next = '0;
                fsis_pkg::CMD_OFFER: begin
                    if (ins_en) begin
                        count_next = count_reg + CNTW'(1);
                    end
                end
                default: count_next = count_reg;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fsis_pkg::ST_IDLE: begin
                if (accept && (s_word.command == fsis_pkg::CMD_READ)) begin
                    state_next = fsis_pkg::ST_SEL;
                end
            end
            fsis_pkg::ST_SEL: state_next = fsis_pkg::ST_OUT;
            fsis_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = fsis_pkg::ST_IDLE;
                end
            end
            default: state_next = fsis_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fsis_pkg::ST_IDLE;
            count_reg <= '0;
            mode_reg <= fsis_pkg::MODE_ALL;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pos_valid_reg <= pos_valid;
        end
        if (state_reg == fsis_pkg::ST_SEL) begin
            m_word_reg.sorted_item_id <= pos_valid_reg ? sel_id : 8'd0;
            m_word_reg.list_count <= count_ext[8:0];
            m_word_reg.position_valid <= pos_valid_reg;
        end
    end

endmodule

/* hdl/fsis_checker.sv */
// Port-level checker for the filtered stable insertion sorter, bound to the top level.
// Depends on fsis_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fsis_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input fsis_pkg::in_word_t  s_word,
    input logic                m_valid,
    input logic                m_ready,
    input fsis_pkg::out_word_t m_word
);

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_word))
    `ASSERT_SAME(a_invalid_zero, aclk, aresetn, m_valid && !m_word.position_valid, m_word.sorted_item_id == 8'd0)
    `ASSERT_NEXT(a_read_busy, aclk, aresetn, s_valid && s_ready && (s_word.command == fsis_pkg::CMD_READ), !s_ready)
    `ASSERT_SAME(a_one_at_a_time, aclk, aresetn, m_valid, !s_ready)

endmodule

bind filtered_stable_insertion_sorter fsis_checker u_fsis_checker (.*);
